>>> rtl/core/seq_pkg.sv
package seq_pkg;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Shift command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic extract;
	} shift_ctl_t;

endpackage

>>> rtl/core/seq_cell.sv
module seq_cell #(
	parameter int TIME_BITS = 48,
	parameter int TAG_BITS  = 16
) (
	input  logic                 clk,
	input  seq_pkg::shift_ctl_t  ctl,
	input  logic                 occupied,
	input  logic [TIME_BITS-1:0] new_time,
	input  logic [TAG_BITS-1:0]  new_tag,
	input  logic                 prev_keep,
	input  logic [TIME_BITS-1:0] left_time,
	input  logic [TAG_BITS-1:0]  left_tag,
	input  logic [TIME_BITS-1:0] right_time,
	input  logic [TAG_BITS-1:0]  right_tag,
	output logic                 keep,
	output logic [TIME_BITS-1:0] time_q,
	output logic [TAG_BITS-1:0]  tag_q
);

	// A stored event of equal or earlier time stays ahead of the new one
	assign keep = occupied && (time_q <= new_time);

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (!keep) begin
				if (prev_keep) begin
					time_q <= new_time;
					tag_q  <= new_tag;
				end else begin
					time_q <= left_time;
					tag_q  <= left_tag;
				end
			end
		end else if (ctl.extract) begin
			time_q <= right_time;
			tag_q  <= right_tag;
		end
	end

endmodule

>>> rtl/core/sorted_event_queue_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  req_type, event_time, event_tag
// out      output     out_valid/ out_ready status, taken_time, taken_tag, head_valid,
//                                          head_time, head_tag, occupancy
//
// One request per cycle while in_ready is high: every cell compares its time
// with the new event and shifts in the same cycle, and the result lands in the
// output register in the cycle after acceptance. in_ready drops only while a
// result waits and out_ready is low. Reset empties the queue at once; cell
// contents are left as they are and are never read before being written.
module sorted_event_queue_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 48,
	parameter int TAG_BITS    = 16,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [TAG_BITS-1:0]  event_tag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [TIME_BITS-1:0] taken_time,
	output logic [TAG_BITS-1:0]  taken_tag,
	output logic                 head_valid,
	output logic [TIME_BITS-1:0] head_time,
	output logic [TAG_BITS-1:0]  head_tag,
	output logic [CNT_W-1:0]     occupancy
);

	logic                 accept;
	logic                 is_insert;
	logic                 full;
	logic                 empty;
	seq_pkg::shift_ctl_t  ctl;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [QUEUE_DEPTH-1:0] occupied;
	logic [QUEUE_DEPTH-1:0] keep;
	logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]  cell_tag  [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] head_time_d;
	logic [TAG_BITS-1:0]  head_tag_d;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [TIME_BITS-1:0] taken_time_q;
	logic [TAG_BITS-1:0]  taken_tag_q;
	logic                 head_valid_q;
	logic [TIME_BITS-1:0] head_time_q;
	logic [TAG_BITS-1:0]  head_tag_q;
	logic [CNT_W-1:0]     occupancy_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_insert = (req_type == seq_pkg::REQ_INSERT);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign ctl.insert  = accept && is_insert && !full;
	assign ctl.extract = accept && !is_insert && !empty;

	always_comb begin
		count_d = count_q;
		if (ctl.insert) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.extract) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 prev_keep;
		logic [TIME_BITS-1:0] left_time;
		logic [TAG_BITS-1:0]  left_tag;
		logic [TIME_BITS-1:0] right_time;
		logic [TAG_BITS-1:0]  right_tag;

		assign occupied[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_keep = 1'b1;
			assign left_time = event_time;
			assign left_tag  = event_tag;
		end else begin : g_inner
			assign prev_keep = keep[i-1];
			assign left_time = cell_time[i-1];
			assign left_tag  = cell_tag[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_time = '0;
			assign right_tag  = '0;
		end else begin : g_mid
			assign right_time = cell_time[i+1];
			assign right_tag  = cell_tag[i+1];
		end

		seq_cell #(
			.TIME_BITS(TIME_BITS),
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[i]),
			.new_time  (event_time),
			.new_tag   (event_tag),
			.prev_keep (prev_keep),
			.left_time (left_time),
			.left_tag  (left_tag),
			.right_time(right_time),
			.right_tag (right_tag),
			.keep      (keep[i]),
			.time_q    (cell_time[i]),
			.tag_q     (cell_tag[i])
		);
	end

	// Head after this request, read ahead of the cell update
	always_comb begin
		head_time_d = cell_time[0];
		head_tag_d  = cell_tag[0];
		if (ctl.insert && !keep[0]) begin
			head_time_d = event_time;
			head_tag_d  = event_tag;
		end else if (ctl.extract) begin
			head_time_d = cell_time[1];
			head_tag_d  = cell_tag[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_insert) begin
				status_q <= full ? seq_pkg::STATUS_FULL : seq_pkg::STATUS_OK;
			end else begin
				status_q <= empty ? seq_pkg::STATUS_EMPTY : seq_pkg::STATUS_OK;
			end
			taken_time_q <= ctl.extract ? cell_time[0] : '0;
			taken_tag_q  <= ctl.extract ? cell_tag[0] : '0;
			head_valid_q <= (count_d != '0);
			head_time_q  <= (count_d != '0) ? head_time_d : '0;
			head_tag_q   <= (count_d != '0) ? head_tag_d : '0;
			occupancy_q  <= count_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign taken_time = taken_time_q;
	assign taken_tag  = taken_tag_q;
	assign head_valid = head_valid_q;
	assign head_time  = head_time_q;
	assign head_tag   = head_tag_q;
	assign occupancy  = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("event count beyond queue depth");

	a_keep_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(keep[QUEUE_DEPTH-1:1] & ~keep[QUEUE_DEPTH-2:0]) == '0)
		else $error("stored events out of order against new event");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occupied[1] |-> (cell_time[0] <= cell_time[1]))
		else $error("head later than second event");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_insert && full) |=> (count_q == CNT_W'(QUEUE_DEPTH)))
		else $error("dropped insert changed the count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (occupancy_q == count_q))
		else $error("reported occupancy differs from count");

endmodule
